### sv/bpr_pkg.sv
// Package for the Pascal-row binomial unit: field widths, store geometry,
// and the command and status bundles shared by the top level and the sweep engine.
// No dependencies.
package bpr_pkg;

  localparam int MAX_N     = 63;
  localparam int ROW_DEPTH = 32;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int N_W       = 6;
  localparam int K_W       = 7;
  localparam int COEF_W    = 63;

  typedef logic [N_W-1:0]    n_t;
  typedef logic [ROW_AW-1:0] addr_t;
  typedef logic [COEF_W-1:0] coef_t;

  // Start request from the front end to the sweep engine.
  typedef struct packed {
    logic  start;
    n_t    n;
    addr_t kk;
  } cmd_t;

  // Completion report from the sweep engine.
  typedef struct packed {
    logic  done;
    coef_t coef;
  } sts_t;

endpackage

### sv/bpr_if.sv
// Valid/ready channel interfaces for the binomial unit's input and result beats.
// Depends on bpr_pkg for field widths.
interface bpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpr_pkg::N_W-1:0]        n;
  logic signed [bpr_pkg::K_W-1:0] k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpr_pkg::COEF_W-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

### sv/binomial_pascal_row_unit.sv
// Binomial coefficient n choose k by Pascal's triangle in a one-row RAM.
// Trivial pairs (k out of range, k zero or equal to n) skip the sweep and
// go straight to the result; otherwise the engine sweeps rows i=1..n over
// entries up to kk = min(k, n-k), reading through the single RAM read port,
// one entry per cycle, plus the E_LAST and E_WR1 states to close out each row.
// One item in flight; the next beat is taken as the result is offered. Async reset.
module binomial_pascal_row_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpr_in_if.sink     in_i,
  bpr_out_if.source  out_o
);

  // Front-end control: take a beat, run the sweep (or short-cut), hold result.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;

  bpr_pkg::coef_t res_q, res_d;
  bpr_pkg::coef_t coef_q, coef_d;
  logic           out_valid_q, out_valid_d;

  bpr_pkg::cmd_t  cmd;
  bpr_pkg::sts_t  sts;

  logic           acc;
  logic           k_neg;
  bpr_pkg::n_t    k_mag;
  bpr_pkg::n_t    kk_full;
  logic           k_over;
  logic           k_edge;
  logic           n_over;
  logic           kk_over;
  logic           out_free;

  // Decode the pair: sign, range and the symmetric reduction of k.
  always_comb begin
    k_neg   = in_i.k[bpr_pkg::K_W-1];
    k_mag   = in_i.k[bpr_pkg::N_W-1:0];
    k_over  = !k_neg && (k_mag > in_i.n);
    k_edge  = !k_neg && ((k_mag == '0) || (k_mag == in_i.n));
    n_over  = (bpr_pkg::N_W + 1)'(in_i.n) > (bpr_pkg::N_W + 1)'(bpr_pkg::MAX_N);
    kk_full = (k_mag > (in_i.n >> 1)) ? (in_i.n - k_mag) : k_mag;
    kk_over = (bpr_pkg::N_W + 1)'(kk_full) >= (bpr_pkg::N_W + 1)'(bpr_pkg::ROW_DEPTH);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    coef_d      = coef_q;
    out_valid_d = out_valid_q;
    cmd.start   = 1'b0;
    cmd.n       = in_i.n;
    cmd.kk      = kk_full[bpr_pkg::ROW_AW-1:0];

    // Drop the result beat once taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (n_over || k_neg || k_over) begin
            res_d   = '0;
            state_d = S_HOLD;
          end else if (k_edge) begin
            res_d   = bpr_pkg::COEF_W'(1);
            state_d = S_HOLD;
          end else if (kk_over) begin
            res_d   = '0;
            state_d = S_HOLD;
          end else begin
            // Hand the reduced pair to the sweep engine.
            cmd.start = 1'b1;
            state_d   = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (sts.done) begin
          res_d   = sts.coef;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        // Advance into the output register as soon as it frees up.
        if (out_free) begin
          coef_d      = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  bpr_sweep u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    coef_q <= coef_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.coefficient = coef_q;

  // The engine reports completion only while a sweep is owed to the front end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> (state_q == S_RUN))
    else $error("sweep done outside of run");

  // A new result beat appears only from the hold stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_HOLD))
    else $error("result beat without held result");

  // k equal to zero short-cuts to one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_i.k == '0)) |=> (res_q == bpr_pkg::COEF_W'(1)) && (state_q == S_HOLD))
    else $error("k of zero did not give one");

endmodule

### sv/bpr_sweep.sv
// Sweep engine: holds one row of Pascal's triangle in a synchronous RAM and
// updates it row by row with read-modify-write passes. Depends on bpr_pkg.
module bpr_sweep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpr_pkg::cmd_t cmd_i,
  output bpr_pkg::sts_t sts_o
);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_READ = 5'b00010,
    E_LAST = 5'b00100,
    E_WR1  = 5'b01000,
    E_DONE = 5'b10000
  } eng_state_e;

  eng_state_e state_q, state_d;

  bpr_pkg::coef_t mem [bpr_pkg::ROW_DEPTH];
  bpr_pkg::coef_t rdata_q;

  bpr_pkg::n_t    n_q, n_d;
  bpr_pkg::n_t    row_q, row_d;
  bpr_pkg::addr_t kk_q, kk_d;
  bpr_pkg::addr_t m_q, m_d;
  bpr_pkg::addr_t raddr_q, raddr_d;
  bpr_pkg::addr_t pend_addr_q, pend_addr_d;
  logic           pend_q, pend_d;
  bpr_pkg::coef_t prev_q, prev_d;
  bpr_pkg::coef_t res_q, res_d;

  logic           re, we;
  bpr_pkg::addr_t waddr;
  bpr_pkg::coef_t wdata;
  bpr_pkg::coef_t val;
  bpr_pkg::n_t    next_row;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    row_d       = row_q;
    kk_d        = kk_q;
    m_d         = m_q;
    raddr_d     = raddr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    prev_d      = prev_q;
    res_d       = res_q;
    re          = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    val         = '0;
    next_row    = row_q + 1'b1;

    // Read data returns: the top entry of a fresh row is taken as zero.
    if (pend_q) begin
      val    = (bpr_pkg::N_W'(pend_addr_q) == row_q) ? '0 : rdata_q;
      prev_d = val;
      if (pend_addr_q != m_q) begin
        we    = 1'b1;
        waddr = pend_addr_q + 1'b1;
        wdata = prev_q + val;
      end
    end

    case (state_q)
      E_IDLE: begin
        if (cmd_i.start) begin
          n_d     = cmd_i.n;
          kk_d    = cmd_i.kk;
          row_d   = bpr_pkg::N_W'(1);
          m_d     = bpr_pkg::ROW_AW'(1);
          raddr_d = bpr_pkg::ROW_AW'(1);
          state_d = E_READ;
        end
      end
      E_READ: begin
        re          = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = raddr_q;
        if (raddr_q == bpr_pkg::ROW_AW'(1)) begin
          state_d = E_LAST;
        end else begin
          raddr_d = raddr_q - 1'b1;
        end
      end
      E_LAST: begin
        state_d = E_WR1;
      end
      E_WR1: begin
        // Entry 0 is always one: row[1] = old row[1] + 1.
        we    = 1'b1;
        waddr = bpr_pkg::ROW_AW'(1);
        wdata = prev_q + bpr_pkg::COEF_W'(1);
        if (row_q == n_q) begin
          state_d = E_DONE;
        end else begin
          row_d   = next_row;
          m_d     = (next_row < bpr_pkg::N_W'(kk_q)) ? next_row[bpr_pkg::ROW_AW-1:0] : kk_q;
          raddr_d = m_d;
          state_d = E_READ;
        end
      end
      E_DONE: begin
        state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase

    if (we && (waddr == kk_q)) begin
      res_d = wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    row_q       <= row_d;
    kk_q        <= kk_d;
    m_q         <= m_d;
    raddr_q     <= raddr_d;
    pend_addr_q <= pend_addr_d;
    prev_q      <= prev_d;
    res_q       <= res_d;
  end

  assign sts_o.done = (state_q == E_DONE);
  assign sts_o.coef = res_q;

endmodule

### tb/testbench.sv
// Self-checking bench for binomial_pascal_row_unit: random and corner (n, k) beats in,
// each coefficient checked against a closed-form n-choose-k predictor.
// Depends on bpr_pkg, bpr_in_if / bpr_out_if and the unit itself.
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [bpr_pkg::K_W-1:0] k_t;

  // One pending input beat; hold_for_drain keeps it back until every
  // coefficient in flight has come out.
  typedef struct {
    bpr_pkg::n_t n;
    k_t          k;
    bit          hold_for_drain;
  } pair_t;

  // One coefficient still owed by the unit, with the pair that asked for it.
  typedef struct {
    bpr_pkg::n_t    n;
    k_t             k;
    bpr_pkg::coef_t coef;
  } coef_exp_t;

  logic clk_i;
  logic rst_ni;

  bpr_in_if  in_if ();
  bpr_out_if out_if ();

  binomial_pascal_row_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pair_t     pair_q[$];
  coef_exp_t coef_q[$];
  int        err_cnt   = 0;
  int        beats_in  = 0;
  int        in_gap    = 0;
  int        out_stall = 0;
  bit        in_acc    = 1'b0;
  bit        quiet     = 1'b0;

  // 12 ns clock, low phase first.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // n choose k by the multiplicative formula. Each partial product is itself
  // a binomial coefficient, so the division is exact; 128 bits hold the
  // largest intermediate (C(63,31) times 31).
  function automatic bpr_pkg::coef_t binom_coef(input bpr_pkg::n_t n, input k_t k);
    int           nv;
    int           kv;
    int           kk;
    logic [127:0] acc;
    nv = int'(n);
    kv = int'(k);
    if (nv > bpr_pkg::MAX_N) return '0;
    if (kv < 0 || kv > nv) return '0;
    if (kv == 0 || kv == nv) return bpr_pkg::coef_t'(1);
    // Fold onto the shorter half of the row.
    kk = (kv > nv / 2) ? nv - kv : kv;
    if (kk >= bpr_pkg::ROW_DEPTH) return '0;
    acc = 128'd1;
    for (int i = 1; i <= kk; i++) acc = acc * (nv - kk + i) / i;
    return bpr_pkg::coef_t'(acc);
  endfunction

  // Gap after an input beat: mostly none or short, now and then long,
  // and none at all while a quiet stretch is on.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: advance on the falling edge. A raised valid stays up with
  // the same pair until the beat is taken; only then is a gap drawn.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_if.valid;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_acc) begin
        void'(pair_q.pop_front());
        beats_in++;
        // Every 64 beats, draw anew whether a quiet stretch or normal idling is on.
        if (beats_in % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
        in_gap    = pick_gap();
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pair_q.size() != 0 &&
                     (!pair_q[0].hold_for_drain || coef_q.size() == 0)) begin
          nxt_valid = 1'b1;
          in_if.n  <= pair_q[0].n;
          in_if.k  <= pair_q[0].k;
        end
      end
    end
    in_if.valid <= nxt_valid;
  end

  // Result-side backpressure: drop ready for random stretches, mostly short,
  // occasionally long; no new stretch starts during a quiet stretch.
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else if (quiet || r < 65) begin
      out_if.ready <= 1'b1;
    end else if (r < 94) begin
      out_stall = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_stall = $urandom_range(10, 60);
      out_if.ready <= 1'b0;
    end
  end

  // Monitor: sample both channels on the rising edge. Check the result beat
  // first, then record the prediction for an accepted input beat, so both
  // queue updates happen in one process.
  always @(posedge clk_i) begin
    coef_exp_t e;
    if (!rst_ni) begin
      in_acc <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (coef_q.size() == 0) begin
          $display("%0t: unexpected result beat, coefficient %0d", $time,
                   out_if.coefficient);
          err_cnt++;
        end else begin
          e = coef_q.pop_front();
          if (out_if.coefficient !== e.coef) begin
            $display("%0t: coefficient mismatch for n=%0d k=%0d: expected %0d, actual %0d",
                     $time, e.n, e.k, e.coef, out_if.coefficient);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        e.n    = in_if.n;
        e.k    = in_if.k;
        e.coef = binom_coef(in_if.n, in_if.k);
        coef_q.push_back(e);
      end
      in_acc <= in_if.valid && in_if.ready;
    end
  end

  // Push one pair onto the stimulus queue.
  task automatic add_pair(input int n, input int k, input bit hold);
    pair_t p;
    p.n              = bpr_pkg::n_t'(n);
    p.k              = k_t'(k);
    p.hold_for_drain = hold;
    pair_q.push_back(p);
  endtask

  // Stimulus and end of run.
  initial begin
    int n;
    int k;
    int r;
    in_if.valid  = 1'b0;
    in_if.n      = '0;
    in_if.k      = '0;
    out_if.ready = 1'b0;
    rst_ni       = 1'b0;

    // Corners: zero row, full row both ends, the widest middle coefficients,
    // the symmetry fold, negative k at both extremes, k beyond n.
    add_pair(0, 0, 0);
    add_pair(63, 0, 0);
    add_pair(63, 63, 0);
    add_pair(63, 31, 0);
    add_pair(63, 32, 0);
    add_pair(62, 31, 0);
    add_pair(63, 1, 0);
    add_pair(63, 62, 0);
    add_pair(63, -1, 0);
    add_pair(63, -64, 0);
    add_pair(0, -1, 0);
    add_pair(0, 1, 0);
    add_pair(5, 6, 0);
    add_pair(0, 63, 0);
    add_pair(1, 1, 0);
    add_pair(2, 1, 0);
    add_pair(10, 5, 0);
    add_pair(10, 7, 0);
    add_pair(42, 21, 0);
    add_pair(21, 42, 0);

    // Random pairs. Keep most rows short, since the sweep time grows with
    // n times k; k is usually in range, sometimes negative or past n.
    for (int i = 0; i < 700; i++) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(0, 20) : $urandom_range(0, 63);
      r = $urandom_range(0, 99);
      if (r < 70)      k = $urandom_range(0, n);
      else if (r < 85) k = -$urandom_range(1, 64);
      else             k = $urandom_range(n, 63) + ((n == 63) ? 0 : 1);
      if (k > 63) k = 63;
      // Now and then hold the sender until the unit has fully drained.
      add_pair(n, k, (i % 150 == 0));
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pair_q.size() != 0) @(posedge clk_i);
    while (coef_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

endmodule
